FILE: rtl/core/aip_pkg.sv
// Shared types and constants for the ASCII integer parser core.
// Depends on nothing; every other file in rtl/core uses it.
package aip_pkg;

   // Result status codes; ST_OK also marks "no error recorded"
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_INVALID  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // Conversion modes as latched from the command field
   typedef enum logic [1:0] {
      MODE_UDEC = 2'd0,
      MODE_SDEC = 2'd1,
      MODE_HEX  = 2'd2,
      MODE_BAD  = 2'd3
   } mode_type;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned NIB_W   = 4;

   // Largest accumulator that can still take *10 + digit (with digit <= 5)
   localparam logic [VALUE_W-1:0] DEC_TENTH     = 64'd1844674407370955161;
   localparam logic [NIB_W-1:0]   DEC_TENTH_REM = 4'd5;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;

   // Letters a..f / A..F map to 10..15 by adding this to the low nibble
   localparam logic [NIB_W-1:0] HEX_LETTER_OFS = 4'd9;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Classified character as it travels from the front to the back
   typedef struct packed {
      logic [NIB_W-1:0] nib;
      logic             is_dec;
      logic             is_hex;
      logic             is_minus;
      logic             first;
      logic             last;
      logic             is_empty;
      logic [CMD_W-1:0] command;
   } entry_type;

   // Per-string summary handed to the result stage
   typedef struct packed {
      status_type         err;
      logic               seen;
      logic               neg;
      mode_type           mode;
      logic [VALUE_W-1:0] acc;
   } fin_type;

endpackage

FILE: rtl/core/aip_req_if.sv
// Request channel: one character per transfer with its string marks.
// Depends on aip_pkg for field widths.
interface aip_req_if;
   logic                        valid;
   logic                        ready;
   logic [aip_pkg::CHAR_W-1:0]  char_code;
   logic                        first;
   logic                        last;
   logic                        is_empty;
   logic [aip_pkg::CMD_W-1:0]   command;

   modport source (output valid, char_code, first, last, is_empty, command, input ready);
   modport sink   (input valid, char_code, first, last, is_empty, command, output ready);
endinterface

FILE: rtl/core/aip_rsp_if.sv
// Response channel: one status and 64-bit value per finished string.
// Depends on aip_pkg for field widths.
interface aip_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [aip_pkg::VALUE_W-1:0] value;

   modport source (output valid, status, value, input ready);
   modport sink   (input valid, status, value, output ready);
endinterface

FILE: rtl/core/aip_front.sv
// Front end: accepts request transfers and classifies each character.
// Depends on aip_pkg and aip_req_if; feeds aip_queue.
module aip_front (
   aip_req_if.sink             req_ch,
   input  logic                q_full,
   output logic                push_valid,
   output aip_pkg::entry_type  push_entry
);
   import aip_pkg::*;

   logic [CHAR_W-1:0] c;
   logic              is_upper;
   logic              is_lower;

   assign c        = req_ch.char_code;
   assign is_upper = (c >= CHAR_UA) && (c <= CHAR_UF);
   assign is_lower = (c >= CHAR_LA) && (c <= CHAR_LF);

   // Take a transfer whenever the queue has room
   assign req_ch.ready = !q_full;
   assign push_valid   = req_ch.valid && !q_full;

   // Classify the character; the nibble is the digit value for both bases
   always_comb begin
      push_entry.is_dec   = (c >= CHAR_0) && (c <= CHAR_9);
      push_entry.is_hex   = push_entry.is_dec || is_upper || is_lower;
      push_entry.is_minus = (c == CHAR_MINUS);
      push_entry.nib      = push_entry.is_dec ? c[NIB_W-1:0]
                                              : c[NIB_W-1:0] + HEX_LETTER_OFS;
      push_entry.first    = req_ch.first;
      push_entry.last     = req_ch.last;
      push_entry.is_empty = req_ch.is_empty;
      push_entry.command  = req_ch.command;
   end

endmodule

FILE: rtl/core/aip_queue.sv
// Short FIFO that decouples the classifier from the accumulator stage.
// Depends on aip_pkg for the entry type.
module aip_queue #(
   parameter int unsigned DEPTH = aip_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  aip_pkg::entry_type push_entry,
   output logic               full,
   output logic               pop_valid,
   output aip_pkg::entry_type pop_entry,
   input  logic               pop
);
   import aip_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push_valid) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill level beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && full))
      else $error("push into full queue");

endmodule

FILE: rtl/core/aip_exec.sv
// Back end: applies each classified character to the accumulator state
// and emits a per-string summary. Depends on aip_pkg.
module aip_exec (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  aip_pkg::entry_type q_entry,
   output logic               q_pop,
   output logic               fin_valid,
   output aip_pkg::fin_type   fin,
   input  logic               fin_ready
);
   import aip_pkg::*;

   logic [VALUE_W-1:0] acc_ff, acc_in, acc_e;
   logic               neg_ff, neg_in, neg_e;
   logic               seen_ff, seen_in, seen_e;
   status_type         err_ff, err_in, err_e;
   mode_type           mode_ff, mode_in, mode_e;
   logic               fin_valid_ff, fin_valid_in;
   fin_type            fin_ff, fin_in;
   logic [VALUE_W-1:0] dec_next;
   logic [VALUE_W-1:0] hex_next;
   logic               dec_ovf;
   logic               end_str;

   assign q_pop     = q_valid && (!fin_valid_ff || fin_ready);
   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;
   assign end_str   = q_entry.is_empty || q_entry.last;

   // Start of string: clear per-string state and latch the mode
   always_comb begin
      acc_e  = q_entry.first ? '0 : acc_ff;
      neg_e  = q_entry.first ? 1'b0 : neg_ff;
      seen_e = q_entry.first ? 1'b0 : seen_ff;
      err_e  = q_entry.first ? ST_OK : err_ff;
      mode_e = q_entry.first ? mode_type'(q_entry.command) : mode_ff;
   end

   // Times ten as a shift-add, plus the digit; overflow test in parallel
   assign dec_next = {acc_e[VALUE_W-4:0], 3'b000} + {acc_e[VALUE_W-2:0], 1'b0}
                   + VALUE_W'(q_entry.nib);
   assign hex_next = {acc_e[VALUE_W-5:0], q_entry.nib};
   assign dec_ovf  = (acc_e > DEC_TENTH)
                   || ((acc_e == DEC_TENTH) && (q_entry.nib > DEC_TENTH_REM));

   // Take one character; the first recorded error sticks
   always_comb begin
      acc_in  = acc_e;
      neg_in  = neg_e;
      seen_in = seen_e;
      err_in  = err_e;
      mode_in = mode_e;
      if (q_valid && (err_e == ST_OK)) begin
         unique case (mode_e)
            MODE_HEX: begin
               if (!q_entry.is_hex) begin
                  err_in = ST_INVALID;
               end else if (acc_e[VALUE_W-1 -: NIB_W] != '0) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  acc_in  = hex_next;
                  seen_in = 1'b1;
               end
            end
            MODE_UDEC, MODE_SDEC: begin
               if ((mode_e == MODE_SDEC) && q_entry.is_minus && !seen_e && !neg_e) begin
                  neg_in = 1'b1;
               end else if (!q_entry.is_dec) begin
                  err_in = ST_INVALID;
               end else if (dec_ovf) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  acc_in  = dec_next;
                  seen_in = 1'b1;
               end
            end
            MODE_BAD: begin
               err_in = ST_INVALID;
            end
         endcase
      end

      // An empty item abandons the string and reads as "no digits"
      if (q_entry.is_empty) begin
         acc_in  = '0;
         neg_in  = 1'b0;
         seen_in = 1'b0;
         err_in  = ST_OK;
         mode_in = mode_type'(q_entry.command);
      end

      fin_in.err  = err_in;
      fin_in.seen = seen_in;
      fin_in.neg  = neg_in;
      fin_in.mode = mode_in;
      fin_in.acc  = acc_in;

      // String done: clear all but the mode
      if (end_str) begin
         acc_in  = '0;
         neg_in  = 1'b0;
         seen_in = 1'b0;
         err_in  = ST_OK;
      end
   end

   // Hold the summary until the result stage takes it
   always_comb begin
      fin_valid_in = fin_valid_ff && !fin_ready;
      if (q_pop) begin
         fin_valid_in = end_str;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         err_ff       <= ST_OK;
         mode_ff      <= MODE_UDEC;
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         if (q_pop) begin
            acc_ff  <= acc_in;
            neg_ff  <= neg_in;
            seen_ff <= seen_in;
            err_ff  <= err_in;
            mode_ff <= mode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && end_str) begin
         fin_ff <= fin_in;
      end
   end

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && !fin_ready) |=> (fin_valid_ff && $stable(fin_ff)))
      else $error("pending summary lost or changed");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      err_ff != ST_EMPTY)
      else $error("empty status recorded as a string error");

endmodule

FILE: rtl/core/aip_result.sv
// Result stage: turns a string summary into status and value and holds
// it in the output register. Depends on aip_pkg and aip_rsp_if.
module aip_result (
   input  logic             clock,
   input  logic             reset,
   input  logic             fin_valid,
   input  aip_pkg::fin_type fin,
   output logic             fin_ready,
   aip_rsp_if.source        rsp_ch
);
   import aip_pkg::*;

   logic               rsp_valid_ff;
   status_type         status_ff, status_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               range_ovf;
   logic               load;

   assign fin_ready     = !rsp_valid_ff || rsp_ch.ready;
   assign load          = fin_valid && fin_ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.value  = value_ff;

   // Signed range: magnitude up to 2^63 - 1, or exactly 2^63 when negative
   assign range_ovf = fin.neg ? (fin.acc[VALUE_W-1] && (fin.acc[VALUE_W-2:0] != '0))
                              : fin.acc[VALUE_W-1];

   // Decide status and value
   always_comb begin
      status_in = ST_OK;
      value_in  = '0;
      if (fin.err != ST_OK) begin
         status_in = fin.err;
      end else if (!fin.seen) begin
         status_in = ST_EMPTY;
      end else if (fin.mode == MODE_SDEC) begin
         if (range_ovf) begin
            status_in = ST_OVERFLOW;
         end else begin
            value_in = fin.neg ? (~fin.acc + 1'b1) : fin.acc;
         end
      end else begin
         value_in = fin.acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_ready) begin
         rsp_valid_ff <= fin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         value_ff  <= value_in;
      end
   end

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != ST_OK)) |-> (value_ff == '0))
      else $error("nonzero value with failing status");

endmodule

FILE: rtl/core/ascii_integer_parser_core.sv
// Top level of the ASCII integer parser: front classifier, queue,
// accumulator stage and result register. Depends on aip_pkg and the channel interfaces.
//
// Parses a character stream, one character per req_ch transfer, as an unsigned
// decimal, signed decimal or hexadecimal 64-bit integer and returns one status
// and value on rsp_ch per string. One character is taken every clock cycle
// while the queue has room; the limit is the accumulator update (multiply by
// ten as a shift-add plus digit). When rsp_ch is not stalled, a result
// reaches rsp_ch after its last character has passed through the queue and
// the accumulator stage's summary register, after which the output
// register presents it. Under output stall one result in the output register,
// one pending summary and QUEUE_DEPTH queued characters are held before
// req_ch.ready drops.
module ascii_integer_parser_core #(
   parameter int unsigned QUEUE_DEPTH = aip_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   aip_req_if.sink   req_ch,
   aip_rsp_if.source rsp_ch
);
   import aip_pkg::*;

   logic      q_full;
   logic      push_valid;
   entry_type push_entry;
   logic      q_valid;
   entry_type q_entry;
   logic      q_pop;
   logic      fin_valid;
   fin_type   fin;
   logic      fin_ready;

   // Classify incoming characters
   aip_front u_front (
      .req_ch     (req_ch),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // Decouple front and back
   aip_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry),
      .pop        (q_pop)
   );

   // Accumulate digits and track errors
   aip_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .fin_valid (fin_valid),
      .fin       (fin),
      .fin_ready (fin_ready)
   );

   // Final range check, sign and output register
   aip_result u_result (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin       (fin),
      .fin_ready (fin_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule
